// File: sv/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: result word type and decode constants.
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

  // Lead byte classes: mask and pattern for each sequence length
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // Payload masks
  localparam logic [7:0] Lead2Bits = 8'h1F;
  localparam logic [7:0] Lead3Bits = 8'h0F;
  localparam logic [7:0] Lead4Bits = 8'h07;
  localparam logic [7:0] ContBits  = 8'h3F;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               truncated;
    logic               last_of_text;
  } result_t;

endpackage

`default_nettype wire

// File: sv/u8sd_in_reg.sv
// Input register of the UTF-8 stream decoder: holds one byte word until decoded.
`default_nettype none

module u8sd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_text_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            eot_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eot_q;
  logic       load;

  // Stall while a held word cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eot_o   = eot_q;

endmodule

`default_nettype wire

// File: sv/u8sd_decode.sv
// Decode stage of the UTF-8 stream decoder: sequence state and code point assembly.
`default_nettype none

module u8sd_decode (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  byte_i,
  input  wire logic        eot_i,
  input  wire logic        fire_i,
  output logic             has_result_o,
  output u8sd_pkg::result_t result_o
);
  import u8sd_pkg::*;

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [1:0]         remain_q, remain_d;
  logic [CpWidth-1:0] shifted;

  assign shifted = {partial_q[CpWidth-7:0], byte_i[5:0] & ContBits[5:0]};

  // Classify lead or fold in a following byte
  always_comb begin
    partial_d    = partial_q;
    remain_d     = remain_q;
    has_result_o = 1'b0;
    result_o     = '{code_point: {13'd0, byte_i}, truncated: 1'b0, last_of_text: eot_i};
    if (remain_q == 2'd0) begin
      priority if ((byte_i & Lead2Mask) == Lead2Pat) begin
        partial_d = {13'd0, byte_i & Lead2Bits};
        remain_d  = 2'd1;
      end else if ((byte_i & Lead3Mask) == Lead3Pat) begin
        partial_d = {13'd0, byte_i & Lead3Bits};
        remain_d  = 2'd2;
      end else if ((byte_i & Lead4Mask) == Lead4Pat) begin
        partial_d = {13'd0, byte_i & Lead4Bits};
        remain_d  = 2'd3;
      end else begin
        // single-byte or invalid lead: emit raw value
        has_result_o = 1'b1;
      end
    end else begin
      partial_d = shifted;
      remain_d  = remain_q - 2'd1;
      if (remain_q == 2'd1) begin
        has_result_o        = 1'b1;
        result_o.code_point = shifted;
        partial_d           = '0;
      end
    end
    // Text ended inside a sequence: drop it and emit the replacement
    if (!has_result_o && eot_i) begin
      has_result_o = 1'b1;
      result_o     = '{code_point: Replacement, truncated: 1'b1, last_of_text: 1'b1};
      partial_d    = '0;
      remain_d     = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      remain_q  <= 2'd0;
    end else if (fire_i) begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/u8sd_out_reg.sv
// Output register of the UTF-8 stream decoder: holds one result word for the receiver.
`default_nettype none

module u8sd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire u8sd_pkg::result_t result_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output u8sd_pkg::result_t      result_o
);
  import u8sd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or when the held word leaves this cycle
  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decode stage, output register.
//
// Usage:
//   Input channel carries one byte word per transfer (in_byte_i, end_of_text_i),
//   accepted when in_valid_i is high and in_stall_o is low. end_of_text_i marks
//   the final byte of a text.
//   Output channel carries one code point word (code_point_o, truncated_o,
//   last_of_text_o), taken when out_valid_o is high and out_stall_i is low.
//   Bytes that do not complete a sequence produce no word; a text ending inside
//   a sequence produces U+FFFD with truncated_o and last_of_text_o set.
// Path: an accepted byte is captured in the input register, decoded, and its result is captured in the output register.
// Throughput: one byte per cycle unless a word waits on a stalled output; the sequence state register is
//   updated by combinational logic between the input and output registers.
// Reset: rst_ni clears both valid flags and the sequence state; the block then
//   expects a lead byte.
// Stall: a stalled output word holds; bytes that yield no word keep flowing,
//   while the first byte that yields a word waits in the input register and
//   stalls the input until the output word is taken.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          end_of_text_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [u8sd_pkg::CpWidth-1:0]       code_point_o,
  output logic                               truncated_o,
  output logic                               last_of_text_o
);
  import u8sd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eot;
  logic       advance;
  logic       has_result;
  logic       space;
  result_t    dec_result;
  result_t    out_result;

  // Move the held byte on when its result has room, or when it has no result
  assign advance = held_valid && (!has_result || space);

  u8sd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .advance_i     (advance),
    .valid_o       (held_valid),
    .byte_o        (held_byte),
    .eot_o         (held_eot)
  );

  u8sd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (held_byte),
    .eot_i        (held_eot),
    .fire_i       (advance),
    .has_result_o (has_result),
    .result_o     (dec_result)
  );

  u8sd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (dec_result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign code_point_o   = out_result.code_point;
  assign truncated_o    = out_result.truncated;
  assign last_of_text_o = out_result.last_of_text;

endmodule

`default_nettype wire

// File: sv/u8sd_checker.sv
// Port checker for the UTF-8 stream decoder, bound to the top level.
`default_nettype none

module u8sd_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic [7:0]              in_byte_i,
  input wire logic                    end_of_text_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [u8sd_pkg::CpWidth-1:0] code_point_o,
  input wire logic                    truncated_o,
  input wire logic                    last_of_text_o
);
  import u8sd_pkg::*;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(truncated_o) && $stable(last_of_text_o))
    else $error("output word changed while stalled");

  // Stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i)
      && $stable(end_of_text_i))
    else $error("input word changed while stalled");

  // Replacement word always closes a text
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_of_text_o && code_point_o == Replacement)
    else $error("truncated word not marked last or not U+FFFD");

  // Input stalls only behind a waiting output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // No output word and no input stall during reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (.*);

`default_nettype wire
